>>> design/tec_pkg.sv
// shared types and constants for the triangle enclosing center block
package tec_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_CIRC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AB   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_AC   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BC   = 2'd3;

    localparam logic REG_LIMIT_ON    = 1'b0;
    localparam logic REG_GUARD_LIMIT = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } t_tri;

endpackage

>>> design/tec_front.sv
// front part: config registers, guard count and limit check
module tec_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [tec_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                     i_push,
    input  logic                     i_set_start,
    input  logic                     i_q_full,
    output logic                     o_q_push
);

    logic        r_limit_on;
    logic [15:0] r_guard_limit;
    logic [15:0] r_count;
    logic [15:0] n_count;
    logic [15:0] count_eff;
    logic        accept;
    logic        emit;

    always_comb begin
        accept    = i_push && !i_q_full;
        count_eff = i_set_start ? 16'd0 : r_count;
        emit      = !(r_limit_on && (count_eff >= r_guard_limit));
        n_count   = r_count;
        if (accept) begin
            n_count = count_eff;
            if (emit && (count_eff != 16'hFFFF)) begin
                n_count = count_eff + 16'd1;
            end
        end
    end

    assign o_q_push = accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_on    <= 1'b0;
            r_guard_limit <= '0;
            r_count       <= '0;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tec_pkg::REG_LIMIT_ON:    r_limit_on    <= i_cfg_data[0];
                    tec_pkg::REG_GUARD_LIMIT: r_guard_limit <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> design/tec_queue.sv
// short item queue between front and back parts
module tec_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tec_pkg::t_tri i_data,
    output logic          o_full,
    input  logic          i_take,
    output logic          o_valid,
    output tec_pkg::t_tri o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tec_pkg::t_tri r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_take;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_take = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_take) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_take) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_take && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> design/tec_back.sv
// back part: multiply sequencer, divider and result register
module tec_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  tec_pkg::t_tri              i_item,
    output logic                       o_take,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic signed [15:0]         o_guard_x,
    output logic signed [15:0]         o_guard_y,
    output logic [tec_pkg::KIND_W-1:0] o_point_kind
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_DIV, S_FIX, S_DONE} t_state;

    t_state              r_state;
    tec_pkg::t_tri       r_tri;
    logic signed [16:0]  r_abx, r_aby, r_acx, r_acy, r_bcx, r_bcy;
    logic [3:0]          r_step;
    logic signed [35:0]  r_prod;
    logic signed [51:0]  r_acc;
    logic [32:0]         r_len0, r_len1, r_len2;
    logic signed [33:0]  r_cross;
    logic signed [51:0]  r_ux;
    logic [50:0]         r_remx, r_remy, r_dsh;
    logic [16:0]         r_qx, r_qy;
    logic                r_negx, r_negy;
    logic [4:0]          r_dcnt;
    logic signed [15:0]  r_gx, r_gy;
    logic [1:0]          r_kind;
    logic                r_ovalid;
    logic signed [15:0]  r_ox, r_oy;
    logic [1:0]          r_okind;

    logic signed [17:0]  opa, opb;
    logic                op_sub, op_hi, op_last;
    logic signed [51:0]  term, acc_sum;
    logic [33:0]         lmax, lrest;
    logic [1:0]          longest;
    logic                acute;
    logic signed [16:0]  mx_ab, my_ab, mx_ac, my_ac, mx_bc, my_bc;
    logic signed [15:0]  mid_x, mid_y;
    logic signed [34:0]  dval;
    logic [50:0]         dabs;
    logic [50:0]         uabs_x, uabs_y;
    logic signed [18:0]  fx, fy;

    function automatic logic signed [15:0] clamp19(input logic signed [18:0] v);
        if (v > 19'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -19'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    always_comb begin
        opa = '0; opb = '0; op_sub = 1'b0; op_hi = 1'b0; op_last = 1'b0;
        case (r_step)
            4'd0:  begin opa = 18'(r_abx); opb = 18'(r_abx); end
            4'd1:  begin opa = 18'(r_aby); opb = 18'(r_aby); op_last = 1'b1; end
            4'd2:  begin opa = 18'(r_acx); opb = 18'(r_acx); end
            4'd3:  begin opa = 18'(r_acy); opb = 18'(r_acy); op_last = 1'b1; end
            4'd4:  begin opa = 18'(r_bcx); opb = 18'(r_bcx); end
            4'd5:  begin opa = 18'(r_bcy); opb = 18'(r_bcy); op_last = 1'b1; end
            4'd6:  begin opa = 18'(r_abx); opb = 18'(r_acy); end
            4'd7:  begin opa = 18'(r_aby); opb = 18'(r_acx); op_sub = 1'b1;
                         op_last = 1'b1; end
            4'd8:  begin opa = 18'(r_acy); opb = {1'b0, r_len0[16:0]}; end
            4'd9:  begin opa = 18'(r_acy); opb = {2'b0, r_len0[32:17]}; op_hi = 1'b1; end
            4'd10: begin opa = 18'(r_aby); opb = {1'b0, r_len1[16:0]}; op_sub = 1'b1; end
            4'd11: begin opa = 18'(r_aby); opb = {2'b0, r_len1[32:17]}; op_sub = 1'b1;
                         op_hi = 1'b1; op_last = 1'b1; end
            4'd12: begin opa = 18'(r_abx); opb = {1'b0, r_len1[16:0]}; end
            4'd13: begin opa = 18'(r_abx); opb = {2'b0, r_len1[32:17]}; op_hi = 1'b1; end
            4'd14: begin opa = 18'(r_acx); opb = {1'b0, r_len0[16:0]}; op_sub = 1'b1; end
            default: begin opa = 18'(r_acx); opb = {2'b0, r_len0[32:17]}; op_sub = 1'b1;
                         op_hi = 1'b1; op_last = 1'b1; end
        endcase
        term    = op_hi ? (52'(r_prod) <<< 17) : 52'(r_prod);
        acc_sum = op_sub ? (r_acc - term) : (r_acc + term);
    end

    always_comb begin
        if ((r_len0 >= r_len1) && (r_len0 >= r_len2)) begin
            longest = 2'd0; lmax = 34'(r_len0); lrest = 34'(r_len1) + 34'(r_len2);
        end else if (r_len1 >= r_len2) begin
            longest = 2'd1; lmax = 34'(r_len1); lrest = 34'(r_len0) + 34'(r_len2);
        end else begin
            longest = 2'd2; lmax = 34'(r_len2); lrest = 34'(r_len0) + 34'(r_len1);
        end
        acute = (lrest > lmax) && (acc_sum[33:0] != '0);
        mx_ab = 17'(r_tri.ax) + 17'(r_tri.bx);
        my_ab = 17'(r_tri.ay) + 17'(r_tri.by_coord);
        mx_ac = 17'(r_tri.ax) + 17'(r_tri.cx);
        my_ac = 17'(r_tri.ay) + 17'(r_tri.cy);
        mx_bc = 17'(r_tri.bx) + 17'(r_tri.cx);
        my_bc = 17'(r_tri.by_coord) + 17'(r_tri.cy);
        case (longest)
            2'd0:    begin mid_x = mx_ab[16:1]; mid_y = my_ab[16:1]; end
            2'd1:    begin mid_x = mx_ac[16:1]; mid_y = my_ac[16:1]; end
            default: begin mid_x = mx_bc[16:1]; mid_y = my_bc[16:1]; end
        endcase
        dval   = {r_cross, 1'b0};
        dabs   = 51'(dval[34] ? -dval : dval) << 16;
        uabs_x = 51'(r_ux[51] ? -r_ux : r_ux);
        uabs_y = 51'(acc_sum[51] ? -acc_sum : acc_sum);
        fx = 19'(r_tri.ax) + (r_negx ? -19'(r_qx) : 19'(r_qx));
        fy = 19'(r_tri.ay) + (r_negy ? -19'(r_qy) : 19'(r_qy));
    end

    assign o_take       = (r_state == S_IDLE) && i_valid;
    assign o_empty      = !r_ovalid;
    assign o_guard_x    = r_ox;
    assign o_guard_y    = r_oy;
    assign o_point_kind = r_okind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (i_pop && r_ovalid && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tri  <= i_item;
                        r_abx  <= 17'(i_item.bx) - 17'(i_item.ax);
                        r_aby  <= 17'(i_item.by_coord) - 17'(i_item.ay);
                        r_acx  <= 17'(i_item.cx) - 17'(i_item.ax);
                        r_acy  <= 17'(i_item.cy) - 17'(i_item.ay);
                        r_bcx  <= 17'(i_item.cx) - 17'(i_item.bx);
                        r_bcy  <= 17'(i_item.cy) - 17'(i_item.by_coord);
                        r_step <= '0;
                        r_acc  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= opa * opb;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= op_last ? '0 : acc_sum;
                    r_step  <= r_step + 4'd1;
                    case (r_step)
                        4'd1: begin
                            r_len0  <= acc_sum[32:0];
                            r_state <= S_MUL;
                        end
                        4'd3: begin
                            r_len1  <= acc_sum[32:0];
                            r_state <= S_MUL;
                        end
                        4'd5: begin
                            r_len2  <= acc_sum[32:0];
                            r_state <= S_MUL;
                        end
                        4'd7: begin
                            r_cross <= acc_sum[33:0];
                            if (!acute) begin
                                r_gx    <= mid_x;
                                r_gy    <= mid_y;
                                case (longest)
                                    2'd0:    r_kind <= tec_pkg::KIND_AB;
                                    2'd1:    r_kind <= tec_pkg::KIND_AC;
                                    default: r_kind <= tec_pkg::KIND_BC;
                                endcase
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end
                        4'd11: begin
                            r_ux    <= acc_sum;
                            r_state <= S_MUL;
                        end
                        4'd15: begin
                            r_remx  <= uabs_x;
                            r_remy  <= uabs_y;
                            r_dsh   <= dabs;
                            r_negx  <= r_ux[51] ^ r_cross[33];
                            r_negy  <= acc_sum[51] ^ r_cross[33];
                            r_qx    <= '0;
                            r_qy    <= '0;
                            r_dcnt  <= 5'd16;
                            r_state <= S_DIV;
                        end
                        default: r_state <= S_MUL;
                    endcase
                end
                S_DIV: begin
                    if (r_remx >= r_dsh) begin
                        r_remx <= r_remx - r_dsh;
                        r_qx   <= {r_qx[15:0], 1'b1};
                    end else begin
                        r_qx   <= {r_qx[15:0], 1'b0};
                    end
                    if (r_remy >= r_dsh) begin
                        r_remy <= r_remy - r_dsh;
                        r_qy   <= {r_qy[15:0], 1'b1};
                    end else begin
                        r_qy   <= {r_qy[15:0], 1'b0};
                    end
                    r_dsh  <= r_dsh >> 1;
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == '0) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_gx    <= clamp19(fx);
                    r_gy    <= clamp19(fy);
                    r_kind  <= tec_pkg::KIND_CIRC;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || i_pop) begin
                        r_ox     <= r_gx;
                        r_oy     <= r_gy;
                        r_okind  <= r_kind;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/triangle_enclosing_center.sv
// top level of the triangle enclosing center block
// One triangle per item goes in, and at most one guard point comes out. The front
// part updates the per-set guard count and drops items over the limit in the cycle
// of the push; kept items wait in a small queue. The back part runs each item on
// one shared 18x18 multiplier: 8 multiply-accumulate steps, each a multiply state
// and an accumulate state, settle a right or obtuse triangle; an acute one takes
// 8 more steps and a restoring divider for both offsets. The result register frees
// the back part as soon as the result is written.
module triangle_enclosing_center #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [tec_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic signed [15:0]         i_ax,
    input  logic signed [15:0]         i_ay,
    input  logic signed [15:0]         i_bx,
    input  logic signed [15:0]         i_by_coord,
    input  logic signed [15:0]         i_cx,
    input  logic signed [15:0]         i_cy,
    input  logic                       i_set_start,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [15:0]         o_guard_x,
    output logic signed [15:0]         o_guard_y,
    output logic [tec_pkg::KIND_W-1:0] o_point_kind
);

    tec_pkg::t_tri in_tri;
    tec_pkg::t_tri q_tri;
    logic          q_push;
    logic          q_valid;
    logic          q_take;

    assign in_tri.ax       = i_ax;
    assign in_tri.ay       = i_ay;
    assign in_tri.bx       = i_bx;
    assign in_tri.by_coord = i_by_coord;
    assign in_tri.cx       = i_cx;
    assign in_tri.cy       = i_cy;

    tec_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_set_start (i_set_start),
        .i_q_full    (full),
        .o_q_push    (q_push)
    );

    tec_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (in_tri),
        .o_full  (full),
        .i_take  (q_take),
        .o_valid (q_valid),
        .o_data  (q_tri)
    );

    tec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_item       (q_tri),
        .o_take       (q_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_guard_x    (o_guard_x),
        .o_guard_y    (o_guard_y),
        .o_point_kind (o_point_kind)
    );

endmodule
